/* rtl/core/rti_pkg.sv */
`default_nettype none

package rti_pkg;

    localparam int FIELD_W           = 32;
    localparam int DIST_W            = 31;
    localparam int MAX_W             = 31;
    localparam int EPS_W             = 63;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 63;
    localparam int STATUS_W          = 3;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [EPS_W-1:0]  EPS_RESET   = EPS_W'(43);
    localparam logic [MAX_W-1:0]  MAX_RESET   = '1;
    localparam logic [FIELD_W-1:0] DIR_Y_RESET = FIELD_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6,
        REG_EPSILON  = 3'd7
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_PARALLEL = 3'd1,
        ST_U_OUT    = 3'd2,
        ST_V_OUT    = 3'd3,
        ST_BEHIND   = 3'd4,
        ST_TOO_FAR  = 3'd5
    } t_status;

    // Side information that rides along with an item through the divider.
    typedef struct packed {
        logic    div;     // status still depends on the quotient
        logic    sat;     // quotient does not fit the distance field
        t_status status;  // early status when div is low
    } t_tag;

endpackage

`default_nettype wire

/* rtl/core/rti_if.sv */
`default_nettype none

interface rti_tri_if import rti_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] a_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic signed [FIELD_W-1:0] c_x;
    logic signed [FIELD_W-1:0] c_y;
    logic signed [FIELD_W-1:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface rti_res_if import rti_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;

    modport source (output valid, hit, status, distance, input ready);
    modport sink (input valid, hit, status, distance, output ready);
endinterface

interface rti_cfg_if import rti_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rti_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per stage, MSB first.
module rti_div import rti_pkg::*; #(
    parameter int DW = 102
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DW-1:0]     i_det,
    input  wire logic [DW-1:0]     i_rem,
    input  wire logic [DIST_W-1:0] i_low,
    input  wire t_tag              i_tag,
    output logic                   o_valid,
    output logic [DIST_W-1:0]      o_quo,
    output t_tag                   o_tag
);

    logic [DIST_W-1:0] r_vld;
    logic [DW-1:0]     r_rem [DIST_W];
    logic [DW-1:0]     r_det [DIST_W];
    logic [DIST_W-1:0] r_low [DIST_W];
    logic [DIST_W-1:0] r_quo [DIST_W];
    t_tag              r_tag [DIST_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIST_W-2:0], i_valid};
        end
    end

    for (genvar j = 0; j < DIST_W; j++) begin : g_step
        logic [DW-1:0]     w_rem;
        logic [DW-1:0]     w_det;
        logic [DIST_W-1:0] w_low;
        logic [DIST_W-1:0] w_quo;
        t_tag              w_tag;
        logic [DW-1:0]     w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_det = i_det;
            assign w_low = i_low;
            assign w_quo = '0;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_det = r_det[j-1];
            assign w_low = r_low[j-1];
            assign w_quo = r_quo[j-1];
            assign w_tag = r_tag[j-1];
        end

        assign w_trial = {w_rem[DW-2:0], w_low[DIST_W-1]};
        assign w_ge    = (w_trial >= w_det);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? (w_trial - w_det) : w_trial;
                r_det[j] <= w_det;
                r_low[j] <= {w_low[DIST_W-2:0], 1'b0};
                r_quo[j] <= {w_quo[DIST_W-2:0], w_ge};
                r_tag[j] <= w_tag;
            end
        end
    end

    assign o_valid = r_vld[DIST_W-1];
    assign o_quo   = r_quo[DIST_W-1];
    assign o_tag   = r_tag[DIST_W-1];

endmodule

`default_nettype wire

/* rtl/core/ray_triangle_intersect.sv */
`default_nettype none

// Moller-Trumbore ray/triangle test. The ray sits in eight config registers;
// each item on i_tri is one triangle and gives exactly one result on o_res,
// in order. One triangle enters per clock unless o_res stalls. The pipeline
// holds eight arithmetic stages (edges, cross products, split dot products,
// sign fixup, range tests), a 31-stage restoring divider for the distance
// (one quotient bit per stage), and the output register. Back-pressure on
// o_res freezes the whole pipeline, so nothing is dropped or repeated. Write
// config only while the pipeline is empty.
module ray_triangle_intersect import rti_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rti_cfg_if.sink    i_cfg,
    rti_tri_if.sink    i_tri,
    rti_res_if.source  o_res
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int EW  = CW + 1;          // edges and offsets
    localparam int XW  = 2 * CW + 3;      // cross products
    localparam int LW  = CW + 1;          // low slice of a cross component
    localparam int HW  = XW - LW;         // high slice
    localparam int MW  = 2 * CW + 3;      // partial product
    localparam int DW  = 3 * CW + 6;      // dot products
    localparam int PW  = DW + EPS_W + FB; // parallel compare
    localparam int SW  = DW + DIST_W;     // saturation compare
    localparam int TS  = DIST_W - FB;     // shift between t numerator and quotient
    localparam int PRE = 8;

    localparam int DOT_DET = 0;
    localparam int DOT_UN  = 1;
    localparam int DOT_VN  = 2;
    localparam int DOT_TN  = 3;

    // Config registers
    logic [FIELD_W-1:0] r_org [3];
    logic [FIELD_W-1:0] r_dir [3];
    logic [MAX_W-1:0]   r_max;
    logic [EPS_W-1:0]   r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= DIR_Y_RESET;
            r_dir[2] <= '0;
            r_max    <= MAX_RESET;
            r_eps    <= EPS_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ORIGIN_X: r_org[0] <= i_cfg.data[FIELD_W-1:0];
                REG_ORIGIN_Y: r_org[1] <= i_cfg.data[FIELD_W-1:0];
                REG_ORIGIN_Z: r_org[2] <= i_cfg.data[FIELD_W-1:0];
                REG_DIR_X:    r_dir[0] <= i_cfg.data[FIELD_W-1:0];
                REG_DIR_Y:    r_dir[1] <= i_cfg.data[FIELD_W-1:0];
                REG_DIR_Z:    r_dir[2] <= i_cfg.data[FIELD_W-1:0];
                REG_MAX_DIST: r_max    <= i_cfg.data[MAX_W-1:0];
                REG_EPSILON:  r_eps    <= i_cfg.data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Global advance: the whole pipeline moves unless the output item is stuck
    logic w_en;
    logic r_o_valid;
    assign w_en        = !r_o_valid || o_res.ready;
    assign i_tri.ready = w_en;

    logic [PRE-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PRE-2:0], i_tri.valid};
        end
    end

    // Coordinates: low CW bits, sign extended
    logic signed [EW-1:0] w_a [3];
    logic signed [EW-1:0] w_b [3];
    logic signed [EW-1:0] w_c [3];
    logic signed [EW-1:0] w_org [3];
    logic signed [EW-1:0] w_dir [3];

    assign w_a[0] = EW'(signed'(i_tri.a_x[CW-1:0]));
    assign w_a[1] = EW'(signed'(i_tri.a_y[CW-1:0]));
    assign w_a[2] = EW'(signed'(i_tri.a_z[CW-1:0]));
    assign w_b[0] = EW'(signed'(i_tri.b_x[CW-1:0]));
    assign w_b[1] = EW'(signed'(i_tri.b_y[CW-1:0]));
    assign w_b[2] = EW'(signed'(i_tri.b_z[CW-1:0]));
    assign w_c[0] = EW'(signed'(i_tri.c_x[CW-1:0]));
    assign w_c[1] = EW'(signed'(i_tri.c_y[CW-1:0]));
    assign w_c[2] = EW'(signed'(i_tri.c_z[CW-1:0]));

    for (genvar k = 0; k < 3; k++) begin : g_cfg_ext
        assign w_org[k] = EW'(signed'(r_org[k][CW-1:0]));
        assign w_dir[k] = EW'(signed'(r_dir[k][CW-1:0]));
    end

    // Stage 1: edges and origin offset
    logic signed [EW-1:0] r1_ab [3];
    logic signed [EW-1:0] r1_ac [3];
    logic signed [EW-1:0] r1_of [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= w_b[k] - w_a[k];
                r1_ac[k] <= w_c[k] - w_a[k];
                r1_of[k] <= w_org[k] - w_a[k];
            end
        end
    end

    // Stage 2: cross product terms, P = dir x AC, Q = OA x AB
    logic signed [2*EW-1:0] r2_pm [6];
    logic signed [2*EW-1:0] r2_qm [6];
    logic signed [EW-1:0]   r2_ab [3];
    logic signed [EW-1:0]   r2_ac [3];
    logic signed [EW-1:0]   r2_of [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pm[0] <= w_dir[1] * r1_ac[2];
            r2_pm[1] <= w_dir[2] * r1_ac[1];
            r2_pm[2] <= w_dir[2] * r1_ac[0];
            r2_pm[3] <= w_dir[0] * r1_ac[2];
            r2_pm[4] <= w_dir[0] * r1_ac[1];
            r2_pm[5] <= w_dir[1] * r1_ac[0];
            r2_qm[0] <= r1_of[1] * r1_ab[2];
            r2_qm[1] <= r1_of[2] * r1_ab[1];
            r2_qm[2] <= r1_of[2] * r1_ab[0];
            r2_qm[3] <= r1_of[0] * r1_ab[2];
            r2_qm[4] <= r1_of[0] * r1_ab[1];
            r2_qm[5] <= r1_of[1] * r1_ab[0];
            r2_ab    <= r1_ab;
            r2_ac    <= r1_ac;
            r2_of    <= r1_of;
        end
    end

    // Stage 3: finish cross products
    logic signed [XW-1:0] r3_p [3];
    logic signed [XW-1:0] r3_q [3];
    logic signed [EW-1:0] r3_ab [3];
    logic signed [EW-1:0] r3_ac [3];
    logic signed [EW-1:0] r3_of [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= XW'(r2_pm[2*k]) - XW'(r2_pm[2*k+1]);
                r3_q[k] <= XW'(r2_qm[2*k]) - XW'(r2_qm[2*k+1]);
            end
            r3_ab <= r2_ab;
            r3_ac <= r2_ac;
            r3_of <= r2_of;
        end
    end

    // Stage 4: dot product terms, wide operand split in two slices
    logic signed [EW-1:0] w_u [4][3];
    logic signed [XW-1:0] w_x [4][3];
    logic signed [MW-1:0] r4_lo [4][3];
    logic signed [MW-1:0] r4_hi [4][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[DOT_DET][k] = r3_ab[k];
            w_x[DOT_DET][k] = r3_p[k];
            w_u[DOT_UN][k]  = r3_of[k];
            w_x[DOT_UN][k]  = r3_p[k];
            w_u[DOT_VN][k]  = w_dir[k];
            w_x[DOT_VN][k]  = r3_q[k];
            w_u[DOT_TN][k]  = r3_ac[k];
            w_x[DOT_TN][k]  = r3_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_lo[d][k] <= w_u[d][k] * signed'({1'b0, w_x[d][k][LW-1:0]});
                    r4_hi[d][k] <= w_u[d][k] * signed'(w_x[d][k][XW-1:XW-HW]);
                end
            end
        end
    end

    // Stage 5: recombine slices
    logic signed [DW-1:0] r5_pr [4][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_pr[d][k] <= (DW'(r4_hi[d][k]) <<< LW) + DW'(r4_lo[d][k]);
                end
            end
        end
    end

    // Stage 6: sum components
    logic signed [DW-1:0] r6_dot [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 4; d++) begin
                r6_dot[d] <= r5_pr[d][0] + r5_pr[d][1] + r5_pr[d][2];
            end
        end
    end

    // Stage 7: make the determinant positive
    logic signed [DW-1:0] r7_dot [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 4; d++) begin
                r7_dot[d] <= r6_dot[DOT_DET][DW-1] ? -r6_dot[d] : r6_dot[d];
            end
        end
    end

    // Stage 8: range tests and divider setup
    logic signed [DW:0]   w_uv;
    logic                 w_par;
    logic                 w_uout;
    logic                 w_vout;
    logic                 w_behind;
    logic                 w_sat;
    t_tag                 n_tag;
    logic [DW-1:0]        r8_det;
    logic [DW-1:0]        r8_rem;
    logic [DIST_W-1:0]    r8_low;
    t_tag                 r8_tag;

    assign w_uv     = (DW+1)'(r7_dot[DOT_UN]) + (DW+1)'(r7_dot[DOT_VN]);
    assign w_par    = (r7_dot[DOT_DET] == '0)
                   || (PW'($unsigned(r7_dot[DOT_DET])) < (PW'(r_eps) << FB));
    assign w_uout   = r7_dot[DOT_UN][DW-1] || (r7_dot[DOT_UN] > r7_dot[DOT_DET]);
    assign w_vout   = r7_dot[DOT_VN][DW-1] || (w_uv > (DW+1)'(r7_dot[DOT_DET]));
    assign w_behind = r7_dot[DOT_TN][DW-1] || (r7_dot[DOT_TN] == '0);
    assign w_sat    = SW'($unsigned(r7_dot[DOT_TN]))
                   >= (SW'($unsigned(r7_dot[DOT_DET])) << TS);

    always_comb begin
        n_tag.div    = 1'b0;
        n_tag.sat    = w_sat;
        n_tag.status = ST_HIT;
        if (w_par) begin
            n_tag.status = ST_PARALLEL;
        end else if (w_uout) begin
            n_tag.status = ST_U_OUT;
        end else if (w_vout) begin
            n_tag.status = ST_V_OUT;
        end else if (w_behind) begin
            n_tag.status = ST_BEHIND;
        end else begin
            n_tag.div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_det <= $unsigned(r7_dot[DOT_DET]);
            r8_rem <= DW'(r7_dot[DOT_TN][DW-1:TS]);
            r8_low <= {r7_dot[DOT_TN][TS-1:0], {FB{1'b0}}};
            r8_tag <= n_tag;
        end
    end

    // Distance divider
    logic              w_dv_valid;
    logic [DIST_W-1:0] w_dv_quo;
    t_tag              w_dv_tag;

    rti_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[PRE-1]),
        .i_det   (r8_det),
        .i_rem   (r8_rem),
        .i_low   (r8_low),
        .i_tag   (r8_tag),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_tag   (w_dv_tag)
    );

    // Output register
    t_status           n_status;
    logic [DIST_W-1:0] n_dist;
    t_status           r_o_status;
    logic [DIST_W-1:0] r_o_dist;

    always_comb begin
        n_status = w_dv_tag.status;
        n_dist   = '0;
        if (w_dv_tag.div) begin
            if (w_dv_tag.sat) begin
                n_status = ST_TOO_FAR;
                n_dist   = '1;
            end else if (w_dv_quo <= DIST_W'(1)) begin
                n_status = ST_BEHIND;
                n_dist   = w_dv_quo;
            end else if (w_dv_quo >= DIST_W'(r_max)) begin
                n_status = ST_TOO_FAR;
                n_dist   = w_dv_quo;
            end else begin
                n_status = ST_HIT;
                n_dist   = w_dv_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_status <= n_status;
            r_o_dist   <= n_dist;
        end
    end

    assign o_res.valid    = r_o_valid;
    assign o_res.hit      = (r_o_status == ST_HIT);
    assign o_res.status   = r_o_status;
    assign o_res.distance = r_o_dist;

    // Checks
    a_hit_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.hit == (o_res.status == ST_HIT)))
        else $error("hit flag disagrees with status");

    a_no_dist_on_reject : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status == ST_PARALLEL || o_res.status == ST_U_OUT
                        || o_res.status == ST_V_OUT)
        |-> (o_res.distance == '0))
        else $error("distance reported for a rejected triangle");

    a_hit_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit
        |-> (o_res.distance > DIST_W'(1)) && (o_res.distance < DIST_W'(r_max)))
        else $error("hit distance out of range");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && $stable(r8_tag))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
